// ===== hw/rtl/sde_pkg.sv =====
// ----------------------------------------------------------------------------
// sde_pkg
// Shared types and constants of the string dictionary encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sde_pkg;

   localparam int CELL_BITS  = 3;
   localparam int CELLS      = 1 << CELL_BITS;
   localparam int WORD_W     = 64;
   localparam int LEN_W      = 8;
   localparam int IDX_OUT_W  = 12;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int KW_W       = 6;
   localparam int CAP_W      = 13;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_NULL = 2'd1,
      STATUS_LONG = 2'd2,
      STATUS_FULL = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NULLABLE  = 2'd0,
      CSR_STRICT    = 2'd1,
      CSR_KEY_WIDTH = 2'd2,
      CSR_CAPACITY  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                 hit;
      logic [CELL_BITS-1:0] slot;
   } chain_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sde_if.sv =====
// ----------------------------------------------------------------------------
// sde_if
// Request and response channel interfaces of the string dictionary encoder.
// ----------------------------------------------------------------------------
`default_nettype none

interface sde_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] key_word0;
   logic [63:0] key_word1;
   logic [63:0] key_word2;
   logic [63:0] key_word3;
   logic [7:0]  key_length;
   logic        is_null;

   modport source (output valid, key_word0, key_word1, key_word2, key_word3,
                   key_length, is_null, input ready);
   modport sink (input valid, key_word0, key_word1, key_word2, key_word3,
                 key_length, is_null, output ready);
endinterface

interface sde_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] entry_index;
   logic        is_new;
   logic        value_present;
   logic        truncated;
   logic [1:0]  status;

   modport source (output valid, entry_index, is_new, value_present, truncated,
                   status, input ready);
   modport sink (input valid, entry_index, is_new, value_present, truncated,
                 status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sde_cell.sv =====
// ----------------------------------------------------------------------------
// sde_cell
// One dictionary cell: a slice of the key store and a key comparator that
// joins its hit into the chain passed on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module sde_cell
   import sde_pkg::*;
#(
   parameter int ROWS    = 512,
   parameter int ROW_W   = 9,
   parameter int DATA_W  = 257,
   parameter int CNT_W   = 13,
   parameter int CELL_ID = 0
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ROW_W-1:0]  wr_row,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ROW_W-1:0]  rd_row,
   input  logic [ROW_W-1:0]  cmp_row,
   input  logic [DATA_W-1:0] key,
   input  logic [CNT_W-1:0]  count,
   input  chain_type         chain_in,
   output chain_type         chain_out
);

   localparam int ENT_W = ROW_W + CELL_BITS;
   localparam int CMP_W = (ENT_W > CNT_W) ? ENT_W : CNT_W;

   logic [DATA_W-1:0] mem_ff [ROWS];
   logic [DATA_W-1:0] rd_data_ff;
   logic [ENT_W-1:0]  entry;
   logic              live;
   logic              hit;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_row] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_row];
      end
   end

   assign entry = {cmp_row, CELL_BITS'(CELL_ID)};
   assign live  = CMP_W'(entry) < CMP_W'(count);
   assign hit   = live && (rd_data_ff == key);

   assign chain_out.hit  = chain_in.hit | hit;
   assign chain_out.slot = hit ? CELL_BITS'(CELL_ID) : chain_in.slot;

endmodule

`default_nettype wire

// ===== hw/rtl/string_dictionary_encoder_core.sv =====
// ----------------------------------------------------------------------------
// string_dictionary_encoder_core
// Dictionary encoder for one string column: looks a padded key up in a row of
// search cells and returns its index, or appends it as a new entry.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake          Contents
//   req_ch    in         valid/ready        key words, length, null flag
//   rsp_ch    out        valid/ready        index, new, present, truncated, status
//   csr_*     in         write enable only  nullable, strict, key width, capacity
//
// A request that errors, or arrives with an empty dictionary, skips the search.
// A lookup sweeps the cell rows one per cycle, set by the single read port of
// each cell memory; a hit ends the sweep early.
// Reset clears the entry count and restores the default configuration; no clearing pass is run.
// A waiting response stalls only the final step of the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module string_dictionary_encoder_core
   import sde_pkg::*;
#(
   parameter int MAX_ENTRIES = 4096,
   parameter int KEY_BYTES   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   sde_req_if.sink               req_ch,
   sde_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int KEY_BITS = KEY_BYTES * 8;
   localparam int DATA_W   = KEY_BITS + 1;
   localparam int ROWS     = (MAX_ENTRIES + CELLS - 1) / CELLS;
   localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
   localparam int ENT_W    = ROW_W + CELL_BITS;
   localparam int CW       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int NW       = (ENT_W + 1 > CNT_W) ? ENT_W + 1 : CNT_W;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SRCH = 4'b0010,
      S_WAIT = 4'b0100,
      S_RESP = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic              nullable_ff;
   logic              strict_ff;
   logic [KW_W-1:0]   kw_ff;
   logic [CAP_W-1:0]  cap_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [KEY_BITS-1:0] key_ff;
   logic              null_ff;
   logic              trunc_ff;
   status_type        err_ff;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              cmp_vld_ff;
   logic [ROW_W-1:0]  cmp_row_ff;
   logic              hit_ff, hit_in;
   logic [ENT_W-1:0]  hit_idx_ff, hit_idx_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [IDX_OUT_W-1:0] rsp_idx_ff;
   logic              rsp_new_ff;
   logic              rsp_pres_ff;
   logic              rsp_trunc_ff;
   status_type        rsp_stat_ff;

   logic              accept;
   logic [LEN_W-1:0]  len;
   logic              null_val;
   logic [KW_W-1:0]   kw;
   logic              too_long;
   logic [LEN_W-1:0]  keep;
   logic [255:0]      raw_key;
   logic [KEY_BITS-1:0] key_in;
   status_type        err_in;
   logic              full;
   logic              found;
   logic              last_row;
   logic [NW-1:0]     next_start;
   logic              load_rsp;
   logic              do_write;
   logic [ENT_W-1:0]  wr_ent;
   chain_type         chain_w [CELLS+1];

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      len      = req_ch.is_null ? '0 : req_ch.key_length;
      null_val = req_ch.is_null || (req_ch.key_length == '0);
      if (kw_ff == '0) begin
         kw = KW_W'(1);
      end else if (kw_ff > KW_W'(KEY_BYTES)) begin
         kw = KW_W'(KEY_BYTES);
      end else begin
         kw = kw_ff;
      end
      too_long = len > LEN_W'(kw);
      keep     = too_long ? LEN_W'(kw) : len;
      raw_key  = {req_ch.key_word3, req_ch.key_word2, req_ch.key_word1, req_ch.key_word0};
      for (int b = 0; b < KEY_BYTES; b++) begin
         key_in[b*8 +: 8] = (LEN_W'(b) < keep) ? raw_key[b*8 +: 8] : 8'h00;
      end
      if (null_val && !nullable_ff) begin
         err_in = STATUS_NULL;
      end else if (too_long && strict_ff) begin
         err_in = STATUS_LONG;
      end else begin
         err_in = STATUS_OK;
      end
   end

   assign found      = cmp_vld_ff && chain_w[CELLS].hit;
   assign next_start = NW'({row_ff, {CELL_BITS{1'b0}}}) + NW'(CELLS);
   assign last_row   = (row_ff == ROW_W'(ROWS - 1)) || (next_start >= NW'(count_ff));
   assign full       = (CW'(count_ff) >= CW'(cap_ff)) || (count_ff == CNT_W'(MAX_ENTRIES));
   assign load_rsp   = (state_ff == S_RESP) && (!rsp_vld_ff || rsp_ch.ready);
   assign do_write   = load_rsp && (err_ff == STATUS_OK) && !hit_ff && !full;
   assign wr_ent     = ENT_W'(count_ff);

   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      count_in   = count_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_ch.ready;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               hit_in = 1'b0;
               row_in = '0;
               if (err_in != STATUS_OK || count_ff == '0) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_SRCH;
               end
            end
         end
         S_SRCH: begin
            if (found) begin
               state_in = S_RESP;
            end else if (last_row) begin
               state_in = S_WAIT;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
         S_WAIT: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (load_rsp) begin
               rsp_vld_in = 1'b1;
               state_in   = S_IDLE;
               if (do_write) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (found && (state_ff == S_SRCH || state_ff == S_WAIT)) begin
         hit_in     = 1'b1;
         hit_idx_in = {cmp_row_ff, chain_w[CELLS].slot};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         cmp_vld_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         nullable_ff <= 1'b0;
         strict_ff   <= 1'b1;
         kw_ff       <= KW_W'(32);
         cap_ff      <= CAP_W'(4096);
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= (state_ff == S_SRCH);
         rsp_vld_ff <= rsp_vld_in;
         if (csr_we) begin
            case (csr_index)
               CSR_NULLABLE:  nullable_ff <= csr_wdata[0];
               CSR_STRICT:    strict_ff   <= csr_wdata[0];
               CSR_KEY_WIDTH: kw_ff       <= csr_wdata[KW_W-1:0];
               CSR_CAPACITY:  cap_ff      <= csr_wdata[CAP_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff     <= row_in;
      cmp_row_ff <= row_ff;
      hit_ff     <= hit_in;
      hit_idx_ff <= hit_idx_in;
      if (accept) begin
         key_ff   <= key_in;
         null_ff  <= null_val;
         trunc_ff <= (err_in == STATUS_OK) && too_long;
         err_ff   <= err_in;
      end
      if (load_rsp) begin
         rsp_pres_ff  <= !null_ff;
         rsp_trunc_ff <= trunc_ff;
         rsp_new_ff   <= do_write;
         if (err_ff != STATUS_OK) begin
            rsp_idx_ff  <= '0;
            rsp_stat_ff <= err_ff;
         end else if (hit_ff) begin
            rsp_idx_ff  <= IDX_OUT_W'(hit_idx_ff);
            rsp_stat_ff <= STATUS_OK;
         end else if (full) begin
            rsp_idx_ff  <= '0;
            rsp_stat_ff <= STATUS_FULL;
         end else begin
            rsp_idx_ff  <= IDX_OUT_W'(count_ff);
            rsp_stat_ff <= STATUS_OK;
         end
      end
   end

   assign chain_w[0] = '0;

   for (genvar g = 0; g < CELLS; g++) begin : g_cell
      sde_cell #(
         .ROWS    (ROWS),
         .ROW_W   (ROW_W),
         .DATA_W  (DATA_W),
         .CNT_W   (CNT_W),
         .CELL_ID (g)
      ) u_cell (
         .clock     (clock),
         .wr_en     (do_write && (wr_ent[CELL_BITS-1:0] == CELL_BITS'(g))),
         .wr_row    (wr_ent[ENT_W-1:CELL_BITS]),
         .wr_data   ({null_ff, key_ff}),
         .rd_en     (state_ff == S_SRCH),
         .rd_row    (row_ff),
         .cmp_row   (cmp_row_ff),
         .key       ({null_ff, key_ff}),
         .count     (count_ff),
         .chain_in  (chain_w[g]),
         .chain_out (chain_w[g+1])
      );
   end

   assign rsp_ch.valid         = rsp_vld_ff;
   assign rsp_ch.entry_index   = rsp_idx_ff;
   assign rsp_ch.is_new        = rsp_new_ff;
   assign rsp_ch.value_present = rsp_pres_ff;
   assign rsp_ch.truncated     = rsp_trunc_ff;
   assign rsp_ch.status        = rsp_stat_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sde_checker.sv =====
// ----------------------------------------------------------------------------
// sde_checker
// Port-level checks of the string dictionary encoder, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sde_checker
   import sde_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [IDX_OUT_W-1:0] rsp_index,
   input logic                 rsp_is_new,
   input logic                 rsp_truncated,
   input logic [STATUS_W-1:0]  rsp_status
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index) && $stable(rsp_status))
      else $error("stalled response changed");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> !rsp_is_new && rsp_index == '0)
      else $error("error response carries an index or a new entry");

   a_null_untrunc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_NULL |-> !rsp_truncated)
      else $error("null error reported as truncated");

   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in work");

endmodule

bind string_dictionary_encoder_core sde_checker u_sde_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_index     (rsp_ch.entry_index),
   .rsp_is_new    (rsp_ch.is_new),
   .rsp_truncated (rsp_ch.truncated),
   .rsp_status    (rsp_ch.status)
);

`default_nettype wire

// ===== tb/sv/string_dictionary_encoder_core_checker.sv =====
// ----------------------------------------------------------------------------
// string_dictionary_encoder_core_checker
// Watches the request, response and register ports of the dictionary encoder,
// keeps its own copy of the dictionary and settings, works out the response
// for every accepted request and compares it with what the block returns.
// ----------------------------------------------------------------------------
module string_dictionary_encoder_core_checker
   import sde_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   sde_req_if                    req_ch,
   sde_rsp_if                    rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DICT_DEPTH = 4096;
   localparam int KEY_MAX    = 32;

   typedef struct packed {
      logic [IDX_OUT_W-1:0] entry_index;
      logic                 is_new;
      logic                 value_present;
      logic                 truncated;
      status_type           status;
   } encoding_type;

   bit [255:0]   dict_keys[$];
   bit           dict_null[$];
   encoding_type encodings[$];
   bit           nullable_q;
   bit           strict_q;
   bit [KW_W-1:0]  key_width_q;
   bit [CAP_W-1:0] capacity_q;

   function automatic encoding_type encode(input logic [255:0] raw, input logic [7:0] length,
                                           input logic null_in);
      encoding_type res;
      int           len;
      int           kw;
      int           cap;
      int           keep;
      int           hit_at;
      bit           is_nul;
      bit [255:0]   key;
      len    = length;
      is_nul = null_in || (len == 0);
      res    = '{entry_index: '0, is_new: 1'b0, value_present: !is_nul, truncated: 1'b0,
                 status: STATUS_OK};
      if (is_nul) len = 0;
      kw  = key_width_q == 0 ? 1 : (key_width_q > KEY_MAX ? KEY_MAX : key_width_q);
      cap = capacity_q > DICT_DEPTH ? DICT_DEPTH : capacity_q;
      if (is_nul && !nullable_q) begin
         res.status = STATUS_NULL;
      end else if (len > kw && strict_q) begin
         res.status = STATUS_LONG;
      end else begin
         keep = len;
         if (keep > kw) begin
            keep = kw;
            res.truncated = 1'b1;
         end
         key = raw & ((256'd1 << (8 * keep)) - 256'd1);
         hit_at = -1;
         foreach (dict_keys[i]) begin
            if (hit_at < 0 && dict_null[i] == is_nul && dict_keys[i] == key) hit_at = i;
         end
         if (hit_at >= 0) begin
            res.entry_index = IDX_OUT_W'(hit_at);
         end else if (dict_keys.size() >= cap) begin
            res.status = STATUS_FULL;
         end else begin
            res.entry_index = IDX_OUT_W'(dict_keys.size());
            res.is_new      = 1'b1;
            dict_keys       = {dict_keys, key};
            dict_null       = {dict_null, is_nul};
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      encoding_type want;
      encoding_type got;
      if (reset) begin
         dict_keys.delete();
         dict_null.delete();
         encodings.delete();
         nullable_q  <= 1'b0;
         strict_q    <= 1'b1;
         key_width_q <= 6'd32;
         capacity_q  <= 13'd4096;
         mismatches  <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NULLABLE:  nullable_q  <= csr_wdata[0];
               CSR_STRICT:    strict_q    <= csr_wdata[0];
               CSR_KEY_WIDTH: key_width_q <= csr_wdata[KW_W-1:0];
               CSR_CAPACITY:  capacity_q  <= csr_wdata[CAP_W-1:0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{entry_index: rsp_ch.entry_index, is_new: rsp_ch.is_new,
                    value_present: rsp_ch.value_present, truncated: rsp_ch.truncated,
                    status: status_type'(rsp_ch.status)};
            if (encodings.size() == 0) begin
               if (mismatches < 10) $display("checker: response with no request waiting");
               mismatches <= mismatches + 1;
            end else begin
               want = encodings.pop_front();
               if (got !== want) begin
                  if (mismatches < 10) begin
                     $write("checker: expected idx %0d new %b present %b trunc %b status %s, ",
                            want.entry_index, want.is_new, want.value_present,
                            want.truncated, want.status.name());
                     $display("got idx %0d new %b present %b trunc %b status %0d",
                              got.entry_index, got.is_new, got.value_present,
                              got.truncated, rsp_ch.status);
                  end
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            encodings = {encodings,
                         encode({req_ch.key_word3, req_ch.key_word2, req_ch.key_word1,
                                 req_ch.key_word0}, req_ch.key_length, req_ch.is_null)};
      end
      outstanding <= encodings.size();
   end

endmodule

// ===== tb/sv/string_dictionary_encoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// string_dictionary_encoder_core_tb
// Drives directed and random column values into the dictionary encoder under
// a series of register settings, with random gaps and response stalls, and
// reports the verdict from the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module string_dictionary_encoder_core_tb;
   import sde_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_NULLABLE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    mismatches;
   int                    outstanding;
   bit                    steady = 1'b0;
   int                    rsp_taken = 0;
   int                    rsp_seen = 0;
   int                    rsp_hold = 0;
   logic [255:0]          key_pool[48];

   sde_req_if req_ch ();
   sde_rsp_if rsp_ch ();

   string_dictionary_encoder_core dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   string_dictionary_encoder_core_checker checker_i (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   always #2 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.key_word0 = '0;
      req_ch.key_word1 = '0;
      req_ch.key_word2 = '0;
      req_ch.key_word3 = '0;
      req_ch.key_length = '0;
      req_ch.is_null = 1'b0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready) rsp_taken <= rsp_taken + 1;
   end

   always @(negedge clock) begin
      if (rsp_taken != rsp_seen) begin
         rsp_seen = rsp_taken;
         rsp_hold = steady ? 0 : $urandom_range(0, 3);
      end
      if (rsp_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic send_request(input logic [255:0] key, input logic [7:0] length,
                               input logic null_in);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.key_word0  = key[63:0];
      req_ch.key_word1  = key[127:64];
      req_ch.key_word2  = key[191:128];
      req_ch.key_word3  = key[255:192];
      req_ch.key_length = length;
      req_ch.is_null    = null_in;
      req_ch.valid      = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type index, input int value);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = CSR_DATA_W'(value);
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   task automatic drain;
      req_ch.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic setup(input bit nul_ok, input bit strict, input int kw, input int cap);
      drain();
      write_reg(CSR_NULLABLE, nul_ok);
      write_reg(CSR_STRICT, strict);
      write_reg(CSR_KEY_WIDTH, kw);
      write_reg(CSR_CAPACITY, cap);
   endtask

   function automatic logic [255:0] random_key;
      logic [255:0] k;
      for (int i = 0; i < 8; i++) k[32*i +: 32] = $urandom;
      return k;
   endfunction

   initial begin
      int kw;
      int cap;
      int len;
      logic [255:0] key;
      foreach (key_pool[i]) key_pool[i] = random_key();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request('0, 8'd5, 1'b1);
      send_request(random_key(), 8'd0, 1'b0);
      send_request({256{1'b1}}, 8'd32, 1'b0);
      send_request({256{1'b1}}, 8'd32, 1'b0);
      send_request({256{1'b1}}, 8'd255, 1'b0);
      send_request(key_pool[0], 8'd33, 1'b0);
      send_request('0, 8'd1, 1'b0);
      send_request(key_pool[1], 8'd17, 1'b0);
      setup(1'b1, 1'b0, 0, 8191);
      send_request('0, 8'd0, 1'b1);
      send_request('0, 8'd0, 1'b0);
      send_request({256{1'b1}}, 8'd255, 1'b0);
      send_request('0, 8'd1, 1'b0);
      send_request(key_pool[2], 8'd40, 1'b0);
      setup(1'b1, 1'b0, 63, 0);
      send_request(random_key(), 8'd200, 1'b0);
      send_request({256{1'b1}}, 8'd32, 1'b0);
      send_request(key_pool[3], 8'd3, 1'b1);
      setup(1'b0, 1'b1, 1, 1);
      send_request(key_pool[4], 8'd1, 1'b0);
      send_request(key_pool[4], 8'd2, 1'b0);

      for (int p = 0; p < 12; p++) begin
         case ($urandom_range(0, 6))
            0: kw = 0;
            1: kw = 1;
            2: kw = 32;
            3: kw = 63;
            default: kw = $urandom_range(1, 32);
         endcase
         case ($urandom_range(0, 5))
            0: cap = 0;
            1: cap = 4096;
            2: cap = 8191;
            default: cap = $urandom_range(1, 300);
         endcase
         setup(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), kw, cap);
         steady = (p % 4 == 3);
         for (int n = 0; n < 100; n++) begin
            if (n == 50 && p == 5) drain();
            key = $urandom_range(0, 9) == 0 ? random_key() : key_pool[$urandom_range(0, 47)];
            len = $urandom_range(0, 7) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 40);
            send_request(key, 8'(len), $urandom_range(0, 9) == 0);
         end
      end
      steady = 1'b0;
      drain();
      repeat (20) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("string_dictionary_encoder_core_tb: done, clean");
      else
         $display("string_dictionary_encoder_core_tb: done, errors");
      $finish;
   end

   initial begin
      #10ms;
      $display("string_dictionary_encoder_core_tb: done, errors");
      $finish;
   end

endmodule
